/* src/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg - shared definitions for the bounded double-ended queue
// Sizes, operation and status codes, FSM states, the controller-to-datapath
// command bundle and the circular index helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    // Storage depth and derived widths
    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = OCC_W + 1;

    // Field widths
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Word returned by a pop or peek on an empty queue
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take the operation at the input ports
        logic load;     // move the prepared result into the output register
    } t_cmd;

    // Circular position: (base + offset) mod CAPACITY, offset at most CAPACITY
    function automatic logic [PTR_W-1:0] wrap_pos(input logic [PTR_W-1:0] base,
                                                  input logic [OCC_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl - transaction controller
// Two-state machine: take one operation, then load its result into the
// output register. Owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bdq_pkg::t_cmd      o_cmd
);

    bdq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    // Output register is free, or frees at this edge
    assign out_free = !r_out_valid || i_ready;

    // State and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_ready      = 1'b0;
        case (r_state)
            bdq_pkg::S_IDLE: begin
                o_ready = out_free;
                if (i_valid && out_free) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bdq_pkg::S_LOAD;
                end
            end
            bdq_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = bdq_pkg::S_IDLE;
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // Raise valid on load, drop it once the transaction is taken
    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/bdq_datapath.sv */
// ----------------------------------------------------------------------------
// bdq_datapath - circular buffer datapath
// Head pointer, occupancy count, slot memory with registered read, and the
// output register for data, status and count.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bdq_pkg::t_cmd                       i_cmd,
    input  wire logic        [bdq_pkg::OP_W-1:0]     i_op,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   i_value,
    output logic signed      [bdq_pkg::DATA_W-1:0]   o_data,
    output logic             [bdq_pkg::STATUS_W-1:0] o_status,
    output logic             [bdq_pkg::COUNT_W-1:0]  o_count
);

    logic signed [bdq_pkg::DATA_W-1:0] r_mem [bdq_pkg::CAPACITY];

    logic [bdq_pkg::PTR_W-1:0] r_head, n_head;
    logic [bdq_pkg::OCC_W-1:0] r_occ,  n_occ;

    logic signed [bdq_pkg::DATA_W-1:0] r_rd_data;
    logic signed [bdq_pkg::DATA_W-1:0] r_fix_data, n_fix_data;
    logic                              r_sel_mem,  n_sel_mem;
    bdq_pkg::t_status                  r_status,   n_status;

    logic                      wr_en, rd_en;
    logic [bdq_pkg::PTR_W-1:0] wr_addr, rd_addr;
    logic                      full, empty;

    assign full  = (r_occ >= bdq_pkg::OCC_W'(bdq_pkg::CAPACITY));
    assign empty = (r_occ == '0);

    // Decode the operation against the current pointers
    always_comb begin
        n_head     = r_head;
        n_occ      = r_occ;
        wr_en      = 1'b0;
        wr_addr    = r_head;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        n_status   = bdq_pkg::ST_DONE;
        n_fix_data = '0;
        n_sel_mem  = 1'b0;
        case (bdq_pkg::t_op'(i_op))
            bdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_head  = bdq_pkg::wrap_pos(r_head,
                                  bdq_pkg::OCC_W'(bdq_pkg::CAPACITY - 1));
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    n_occ   = r_occ + bdq_pkg::OCC_W'(1);
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = bdq_pkg::wrap_pos(r_head, r_occ);
                    n_occ   = r_occ + bdq_pkg::OCC_W'(1);
                end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status   = bdq_pkg::ST_EMPTY;
                    n_fix_data = bdq_pkg::INT_MIN;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = r_head;
                    n_sel_mem = 1'b1;
                    if (bdq_pkg::t_op'(i_op) == bdq_pkg::OP_POP_FRONT) begin
                        n_head = bdq_pkg::wrap_pos(r_head, bdq_pkg::OCC_W'(1));
                        n_occ  = r_occ - bdq_pkg::OCC_W'(1);
                    end
                end
            end
            bdq_pkg::OP_POP_BACK, bdq_pkg::OP_PEEK_REAR: begin
                if (empty) begin
                    n_status   = bdq_pkg::ST_EMPTY;
                    n_fix_data = bdq_pkg::INT_MIN;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = bdq_pkg::wrap_pos(r_head, r_occ - bdq_pkg::OCC_W'(1));
                    n_sel_mem = 1'b1;
                    if (bdq_pkg::t_op'(i_op) == bdq_pkg::OP_POP_BACK) begin
                        n_occ = r_occ - bdq_pkg::OCC_W'(1);
                    end
                end
            end
            default: begin
                // unknown operation: leave state alone, report done
            end
        endcase
    end

    // Pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else if (i_cmd.accept) begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

    // Slot memory: at most one write or one registered read per operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (i_cmd.accept && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Hold the decoded result until the load step
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status   <= n_status;
            r_fix_data <= n_fix_data;
            r_sel_mem  <= n_sel_mem;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_data   <= r_sel_mem ? r_rd_data : r_fix_data;
            o_status <= r_status;
            o_count  <= bdq_pkg::COUNT_W'(r_occ);
        end
    end

endmodule

`default_nettype wire

/* src/bounded_double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core - bounded deque of signed 32-bit words
// Each input transaction carries one operation (push, pop or peek at either
// end) and produces exactly one result transaction with data, status, count.
//
// Input channel: i_valid / o_ready with i_op and i_value. Output channel:
// o_valid / i_ready with o_data, o_status and o_count.
// The output register loads at the edge after the one that accepts the
// operation, and the result is valid from that edge on.
// No new operation is taken before the last one has been loaded, as the
// registered read of the slot memory is followed by the output register load.
// A push on a full queue returns status full and leaves the contents alone;
// a pop or peek on an empty queue returns status empty and the most
// negative word. Unknown operation codes return done with zero data.
// Reset (synchronous, active low) empties the queue and clears the output
// valid flag; slot contents are not cleared, no clearing pass is needed.
// While the receiver stalls, the result holds in the output register and
// the next operation is taken only once that result has been accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic        [bdq_pkg::OP_W-1:0]     i_op,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   i_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed      [bdq_pkg::DATA_W-1:0]   o_data,
    output logic             [bdq_pkg::STATUS_W-1:0] o_status,
    output logic             [bdq_pkg::COUNT_W-1:0]  o_count
);

    bdq_pkg::t_cmd cmd;

    // Sequence transactions
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // Execute operations on the buffer
    bdq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_data   (o_data),
        .o_status (o_status),
        .o_count  (o_count)
    );

endmodule

`default_nettype wire

/* src/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker - port-level checks for the bounded deque
// Watches the top level's ports and flags results that break the queue's
// rules; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic signed [bdq_pkg::DATA_W-1:0]   o_data,
    input wire logic        [bdq_pkg::STATUS_W-1:0] o_status,
    input wire logic        [bdq_pkg::COUNT_W-1:0]  o_count
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_status)
                                && $stable(o_count))
        else $error("result changed while stalled");

    // Refused push only when the queue is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bdq_pkg::ST_FULL)
            |-> o_count == bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY))
        else $error("full status with queue not full");

    // Refused pop or peek only when empty, and returns the empty word
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bdq_pkg::ST_EMPTY)
            |-> (o_count == '0) && (o_data == bdq_pkg::INT_MIN))
        else $error("empty status with bad count or data");

    // One operation in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second operation taken while one is in flight");

    // Count never goes beyond capacity on a completed operation
    a_op_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bdq_pkg::ST_DONE)
            |-> o_count <= bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY))
        else $error("count beyond capacity");

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for bounded_double_ended_queue_core
// Drives push, pop and peek operations at both ends through the valid/ready
// input channel, predicts every result with a behavioural model of the
// circular buffer, and checks each output transaction field by field.
// Stimulus runs a directed opening, then fill/drain/mixed random segments
// under several sender and receiver idling patterns, with a long receiver
// hold-off that backs up the input and a sender pause that drains the block.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    // Operation codes outside the defined set; the block must ignore them
    localparam logic [bdq_pkg::OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [bdq_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 420;
    localparam int HOLDOFF_CYCLES  = 200;
    localparam int LIMIT_CYCLES    = 400000;

    typedef struct packed {
        logic signed [bdq_pkg::DATA_W-1:0]   data;
        logic        [bdq_pkg::STATUS_W-1:0] status;
        logic        [bdq_pkg::COUNT_W-1:0]  count;
    } t_deque_result;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } t_seg;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow deque plus the queue of results still owed
    // ------------------------------------------------------------------------
    class t_deque_scoreboard;
        logic signed [bdq_pkg::DATA_W-1:0] slots [bdq_pkg::CAPACITY];
        int unsigned                       head_idx;
        int unsigned                       occupancy;
        t_deque_result                     owed_q [$];
        int unsigned                       mismatches;

        function new();
            head_idx   = 0;
            occupancy  = 0;
            mismatches = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted operation to the shadow deque and queue its result
        function void note_op(input logic [bdq_pkg::OP_W-1:0] op,
                              input logic signed [bdq_pkg::DATA_W-1:0] value);
            t_deque_result res;
            int unsigned   pos;
            res.data   = '0;
            res.status = bdq_pkg::ST_DONE;
            case (op)
                bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                    if (occupancy >= bdq_pkg::CAPACITY) begin
                        res.status = bdq_pkg::ST_FULL;
                    end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
                        head_idx = (head_idx + bdq_pkg::CAPACITY - 1) % bdq_pkg::CAPACITY;
                        slots[head_idx] = value;
                        occupancy++;
                    end else begin
                        slots[(head_idx + occupancy) % bdq_pkg::CAPACITY] = value;
                        occupancy++;
                    end
                end
                bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK,
                bdq_pkg::OP_PEEK_FRONT, bdq_pkg::OP_PEEK_REAR: begin
                    if (occupancy == 0) begin
                        res.status = bdq_pkg::ST_EMPTY;
                        res.data   = bdq_pkg::INT_MIN;
                    end else begin
                        if (op == bdq_pkg::OP_POP_FRONT || op == bdq_pkg::OP_PEEK_FRONT) begin
                            pos = head_idx;
                        end else begin
                            pos = (head_idx + occupancy - 1) % bdq_pkg::CAPACITY;
                        end
                        res.data = slots[pos];
                        if (op == bdq_pkg::OP_POP_FRONT) begin
                            head_idx = (head_idx + 1) % bdq_pkg::CAPACITY;
                            occupancy--;
                        end else if (op == bdq_pkg::OP_POP_BACK) begin
                            occupancy--;
                        end
                    end
                end
                default: begin
                    // unknown code: no change, done with zero data
                end
            endcase
            res.count = bdq_pkg::COUNT_W'(occupancy);
            owed_q = {owed_q, res};
        endfunction

        // Compare one output transaction against the oldest owed result
        function void check_result(input t_deque_result got);
            t_deque_result exp_res;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result data=%0d status=%0d count=%0d",
                         $time, got.data, got.status, got.count);
                mismatches++;
                return;
            end
            exp_res = owed_q[0];
            owed_q.delete(0);
            if (got.data !== exp_res.data) begin
                $display("%0t: data mismatch expected=%0d actual=%0d",
                         $time, exp_res.data, got.data);
                mismatches++;
            end
            if (got.status !== exp_res.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, exp_res.status, got.status);
                mismatches++;
            end
            if (got.count !== exp_res.count) begin
                $display("%0t: count mismatch expected=%0d actual=%0d",
                         $time, exp_res.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic        [bdq_pkg::OP_W-1:0]     i_op    = '0;
    logic signed [bdq_pkg::DATA_W-1:0]   i_value = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [bdq_pkg::DATA_W-1:0]   o_data;
    logic        [bdq_pkg::STATUS_W-1:0] o_status;
    logic        [bdq_pkg::COUNT_W-1:0]  o_count;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int holdoff_left = 0;

    t_deque_scoreboard sb = new();

    bounded_double_ended_queue_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data),
        .o_status (o_status),
        .o_count  (o_count)
    );

    // Clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(20 * LIMIT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: count down a hold-off, otherwise stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready = 1'b0;
        end else if (holdoff_left > 0) begin
            i_ready = 1'b0;
            holdoff_left--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result('{data: o_data, status: o_status, count: o_count});
            end
            if (i_valid && o_ready) begin
                sb.note_op(i_op, i_value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one operation, idling first at random, and hold it until taken
    task automatic send_op(input logic [bdq_pkg::OP_W-1:0] op,
                           input logic signed [bdq_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_op    = op;
        i_value = value;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // Drop valid and wait until every owed result has been received
    task automatic drain_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [bdq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return bdq_pkg::INT_MIN;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Bias the operation mix so the deque swings between full and empty
    function automatic logic [bdq_pkg::OP_W-1:0] pick_op(input t_seg seg);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0) begin
            return ($urandom_range(0, 1) != 0) ? OP_RSVD_HI : OP_RSVD_LO;
        end
        case (seg)
            SEG_FILL: begin
                if (r < 70) return ($urandom_range(0, 1) != 0) ?
                                   bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
                if (r < 85) return ($urandom_range(0, 1) != 0) ?
                                   bdq_pkg::OP_PEEK_REAR : bdq_pkg::OP_PEEK_FRONT;
                return ($urandom_range(0, 1) != 0) ?
                       bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
            end
            SEG_DRAIN: begin
                if (r < 70) return ($urandom_range(0, 1) != 0) ?
                                   bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
                if (r < 85) return ($urandom_range(0, 1) != 0) ?
                                   bdq_pkg::OP_PEEK_REAR : bdq_pkg::OP_PEEK_FRONT;
                return ($urandom_range(0, 1) != 0) ?
                       bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
            end
            default: return 3'($urandom_range(0, 5));
        endcase
    endfunction

    // Run random segments of fill, drain and mixed traffic
    task automatic run_random(input int n_items);
        t_seg seg;
        int   seg_len;
        seg = SEG_FILL;
        while (n_items > 0) begin
            seg_len = $urandom_range(10, 40);
            repeat (seg_len) begin
                if (n_items > 0) begin
                    send_op(pick_op(seg), pick_word());
                    n_items--;
                end
            end
            case ($urandom_range(0, 2))
                0:       seg = SEG_FILL;
                1:       seg = SEG_DRAIN;
                default: seg = SEG_MIX;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty refusals, unknown codes, both ends, wrap of head
        send_op(bdq_pkg::OP_PEEK_FRONT, 32'sd5);
        send_op(bdq_pkg::OP_PEEK_REAR,  32'sd6);
        send_op(bdq_pkg::OP_POP_FRONT,  32'sd7);
        send_op(bdq_pkg::OP_POP_BACK,   32'sd8);
        send_op(OP_RSVD_LO,             32'sd9);
        send_op(OP_RSVD_HI,             32'sd10);
        send_op(bdq_pkg::OP_PUSH_BACK,  bdq_pkg::INT_MIN);
        send_op(bdq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_op(bdq_pkg::OP_PEEK_FRONT, '0);
        send_op(bdq_pkg::OP_PEEK_REAR,  '0);
        send_op(bdq_pkg::OP_PUSH_BACK,  -32'sd1);
        send_op(bdq_pkg::OP_PUSH_FRONT, '0);
        send_op(bdq_pkg::OP_POP_BACK,   '0);
        send_op(bdq_pkg::OP_POP_FRONT,  '0);
        send_op(bdq_pkg::OP_POP_BACK,   '0);
        send_op(bdq_pkg::OP_POP_FRONT,  '0);
        send_op(bdq_pkg::OP_POP_FRONT,  '0);
        drain_block();

        // No idling, with a long receiver hold-off that backs up the input
        gap_pct   = 0;
        stall_pct = 0;
        run_random(ITEMS_PER_PHASE / 2);
        holdoff_left = HOLDOFF_CYCLES;
        run_random(20);
        drain_block();
        run_random(ITEMS_PER_PHASE / 2);

        // Sender idling
        gap_pct   = 81;
        stall_pct = 0;
        run_random(ITEMS_PER_PHASE);

        // Receiver stalling
        gap_pct   = 0;
        stall_pct = 81;
        run_random(ITEMS_PER_PHASE);

        // Both sides idling
        gap_pct   = 27;
        stall_pct = 27;
        run_random(ITEMS_PER_PHASE);

        // Let the last results out, then allow for any stray transaction
        drain_block();
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
